// File: src/qlm_pkg.sv
// ----------------------------------------------------------------------------
// qlm_pkg
// Types, widths and constants shared by the QPSK log-MAP soft demapper.
// ----------------------------------------------------------------------------
package qlm_pkg;

    // Input and result words
    typedef struct packed {
        logic signed [15:0] rx_real;
        logic signed [15:0] rx_imag;
    } rx_word_t;

    typedef struct packed {
        logic signed [15:0] llr_first_bit;
        logic signed [15:0] llr_second_bit;
    } llr_word_t;

    // Register reset: 1.0 in Q8.8
    localparam logic [15:0] INV_NOISE_RESET = 16'd256;

    // Constellation coordinate magnitude 1/sqrt2 in Q.11
    localparam int COORD_Q11 = 1448;

    // Datapath widths
    localparam int E_W    = 17;  // sample minus coordinate
    localparam int SQ_W   = 31;  // squared error, Q.22
    localparam int PROD_W = 47;  // scaled squared error
    localparam int AXM_W  = 25;  // rounded axis metric, Q.7
    localparam int MET_W  = 27;  // signed point metric, Q.7
    localparam int LSE_W  = 28;  // max plus correction
    localparam int LLR_W  = 29;  // LLR before saturation

    // Rounding term and shift for the axis metric
    localparam int RND_SHIFT = 23;

    // Correction covers [0, 8.0) in Q.7
    localparam int CORR_RANGE_Q7 = 1024;
    localparam int CORR_IDX_W    = 10;
    localparam int CORR_W        = 7;
    localparam int MASTER_LEN    = 64;

    // round(128*ln(1+exp(-t))) at t = k/8
    localparam logic [CORR_W-1:0] CORR_MASTER [MASTER_LEN] = '{
        7'd89, 7'd81, 7'd74, 7'd67, 7'd61, 7'd55, 7'd50, 7'd45,
        7'd40, 7'd36, 7'd32, 7'd29, 7'd26, 7'd23, 7'd21, 7'd18,
        7'd16, 7'd14, 7'd13, 7'd11, 7'd10, 7'd9,  7'd8,  7'd7,
        7'd6,  7'd6,  7'd5,  7'd4,  7'd4,  7'd3,  7'd3,  7'd3,
        7'd2,  7'd2,  7'd2,  7'd2,  7'd1,  7'd1,  7'd1,  7'd1,
        7'd1,  7'd1,  7'd1,  7'd1,  7'd1,  7'd0,  7'd0,  7'd0,
        7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,
        7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0
    };

endpackage

// File: src/qlm_axis_metric.sv
// ----------------------------------------------------------------------------
// qlm_axis_metric
// Three-stage per-axis metric: square the error against one coordinate,
// scale by the reciprocal noise variance, round to Q.7.
// ----------------------------------------------------------------------------
module qlm_axis_metric
    import qlm_pkg::*;
(
    input  logic                    clk,
    input  logic                    adv,
    input  logic signed [15:0]      y,
    input  logic signed [E_W-1:0]   coord,
    input  logic        [15:0]      inv_noise_var,
    output logic        [AXM_W-1:0] metric
);

    logic signed [E_W-1:0]    err;
    logic signed [2*E_W-1:0]  err_sq;
    logic        [SQ_W-1:0]   sq_reg;
    logic        [PROD_W-1:0] prod_reg;
    logic        [PROD_W:0]   rounded;
    logic        [AXM_W-1:0]  metric_reg;

    // Square the error; it stays below 2^31
    assign err    = E_W'(y) - coord;
    assign err_sq = err * err;

    // Round half up and drop the fraction
    assign rounded = {1'b0, prod_reg} + ((PROD_W + 1)'(1) << (RND_SHIFT - 1));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg     <= err_sq[SQ_W-1:0];
            prod_reg   <= PROD_W'(sq_reg) * PROD_W'(inv_noise_var);
            metric_reg <= rounded[RND_SHIFT +: AXM_W];
        end
    end

    assign metric = metric_reg;

endmodule

// File: src/qlm_lse_pair.sv
// ----------------------------------------------------------------------------
// qlm_lse_pair
// Two-stage max-star of two point metrics: max and tabled log(1+exp(-x))
// correction, then their sum.
// ----------------------------------------------------------------------------
module qlm_lse_pair
    import qlm_pkg::*;
#(
    parameter int CORR_TABLE_DEPTH = 16
)
(
    input  logic                    clk,
    input  logic                    adv,
    input  logic signed [MET_W-1:0] met_a,
    input  logic signed [MET_W-1:0] met_b,
    output logic signed [LSE_W-1:0] lse
);

    localparam int BIN_W  = $clog2(CORR_TABLE_DEPTH);
    localparam int BPRD_W = CORR_IDX_W + $clog2(CORR_TABLE_DEPTH + 1);

    logic        [CORR_W-1:0] corr_lut [CORR_TABLE_DEPTH];
    logic signed [LSE_W-1:0]  diff;
    logic        [LSE_W-1:0]  mag;
    logic                     in_range;
    logic        [BPRD_W-1:0] bin_prod;
    logic        [BIN_W-1:0]  bin;
    logic signed [MET_W-1:0]  max_reg;
    logic        [CORR_W-1:0] corr_reg;
    logic signed [LSE_W-1:0]  lse_reg;

    // Build the binned table from the master table at elaboration
    for (genvar k = 0; k < CORR_TABLE_DEPTH; k++)
    begin : g_lut
        assign corr_lut[k] = CORR_MASTER[(k * MASTER_LEN) / CORR_TABLE_DEPTH];
    end

    // Distance between the two metrics and its bin
    assign diff     = LSE_W'(met_a) - LSE_W'(met_b);
    assign mag      = diff[LSE_W-1] ? LSE_W'(-diff) : LSE_W'(diff);
    assign in_range = mag < LSE_W'(CORR_RANGE_Q7);
    assign bin_prod = BPRD_W'(mag[CORR_IDX_W-1:0]) * BPRD_W'(CORR_TABLE_DEPTH);
    assign bin      = bin_prod[CORR_IDX_W +: BIN_W];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            max_reg  <= (met_a > met_b) ? met_a : met_b;
            corr_reg <= in_range ? corr_lut[bin] : '0;
            lse_reg  <= LSE_W'(max_reg) + LSE_W'($signed({1'b0, corr_reg}));
        end
    end

    assign lse = lse_reg;

endmodule

// File: src/qpsk_logmap_soft_demapper.sv
// ----------------------------------------------------------------------------
// qpsk_logmap_soft_demapper
// QPSK log-MAP soft demapper: two saturated Q8.7 LLRs per I/Q sample.
// ----------------------------------------------------------------------------
// Stages in order: axis metrics, point metrics, max-star, output word.
// Throughput: one word per cycle; the seven-stage pipeline halts as a whole
// only while the output stage holds a word that is not taken.
// Reset: rst_n clears all pipeline valid bits and sets inv_noise_var to 1.0.
// ----------------------------------------------------------------------------
module qpsk_logmap_soft_demapper
    import qlm_pkg::*;
#(
    parameter int CORR_TABLE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  rx_word_t    rx_data,
    output logic        llr_valid,
    input  logic        llr_ready,
    output llr_word_t   llr_data,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    localparam int PIPE_DEPTH = 7;

    logic                    adv;
    logic [PIPE_DEPTH-1:0]   valid_reg;
    logic [PIPE_DEPTH-1:0]   valid_next;
    logic [15:0]             inv_noise_reg;
    logic [AXM_W-1:0]        m_real [2];
    logic [AXM_W-1:0]        m_imag [2];
    logic signed [MET_W-1:0] met_reg [4];
    logic signed [LSE_W-1:0] lse_one_first;
    logic signed [LSE_W-1:0] lse_zero_first;
    logic signed [LSE_W-1:0] lse_one_second;
    logic signed [LSE_W-1:0] lse_zero_second;
    logic signed [LLR_W-1:0] llr_first;
    logic signed [LLR_W-1:0] llr_second;
    llr_word_t               out_reg;

    // Saturate an LLR to 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [LLR_W-1:0] v);
        logic signed [15:0] r;
        if (v > LLR_W'(32767))
            r = 16'sd32767;
        else if (v < -LLR_W'(32768))
            r = -16'sd32768;
        else
            r = v[15:0];
        return r;
    endfunction

    // Advance the whole pipeline unless the output word is stalled
    assign adv      = !valid_reg[PIPE_DEPTH-1] || llr_ready;
    assign rx_ready = adv;

    assign valid_next = {valid_reg[PIPE_DEPTH-2:0], rx_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the reciprocal noise variance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_noise_reg <= INV_NOISE_RESET;
        end
        else if (cfg_wr_en)
        begin
            inv_noise_reg <= cfg_wr_data;
        end
    end

    // Axis metrics against +a and -a on each axis
    qlm_axis_metric u_real_pos (
        .clk           (clk),
        .adv           (adv),
        .y             (rx_data.rx_real),
        .coord         (E_W'(COORD_Q11)),
        .inv_noise_var (inv_noise_reg),
        .metric        (m_real[0])
    );

    qlm_axis_metric u_real_neg (
        .clk           (clk),
        .adv           (adv),
        .y             (rx_data.rx_real),
        .coord         (-E_W'(COORD_Q11)),
        .inv_noise_var (inv_noise_reg),
        .metric        (m_real[1])
    );

    qlm_axis_metric u_imag_pos (
        .clk           (clk),
        .adv           (adv),
        .y             (rx_data.rx_imag),
        .coord         (E_W'(COORD_Q11)),
        .inv_noise_var (inv_noise_reg),
        .metric        (m_imag[0])
    );

    qlm_axis_metric u_imag_neg (
        .clk           (clk),
        .adv           (adv),
        .y             (rx_data.rx_imag),
        .coord         (-E_W'(COORD_Q11)),
        .inv_noise_var (inv_noise_reg),
        .metric        (m_imag[1])
    );

    // Point metrics: minus the sum of the two axis metrics
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                met_reg[i] <= -$signed(
                    MET_W'(m_real[(i >> 1) & 1]) + MET_W'(m_imag[i & 1]));
            end
        end
    end

    // Max-star over the point pairs of each bit
    qlm_lse_pair #(.CORR_TABLE_DEPTH(CORR_TABLE_DEPTH)) u_lse_one_first (
        .clk   (clk),
        .adv   (adv),
        .met_a (met_reg[2]),
        .met_b (met_reg[3]),
        .lse   (lse_one_first)
    );

    qlm_lse_pair #(.CORR_TABLE_DEPTH(CORR_TABLE_DEPTH)) u_lse_zero_first (
        .clk   (clk),
        .adv   (adv),
        .met_a (met_reg[0]),
        .met_b (met_reg[1]),
        .lse   (lse_zero_first)
    );

    qlm_lse_pair #(.CORR_TABLE_DEPTH(CORR_TABLE_DEPTH)) u_lse_one_second (
        .clk   (clk),
        .adv   (adv),
        .met_a (met_reg[1]),
        .met_b (met_reg[3]),
        .lse   (lse_one_second)
    );

    qlm_lse_pair #(.CORR_TABLE_DEPTH(CORR_TABLE_DEPTH)) u_lse_zero_second (
        .clk   (clk),
        .adv   (adv),
        .met_a (met_reg[0]),
        .met_b (met_reg[2]),
        .lse   (lse_zero_second)
    );

    // Subtract and saturate into the output word
    assign llr_first  = LLR_W'(lse_one_first) - LLR_W'(lse_zero_first);
    assign llr_second = LLR_W'(lse_one_second) - LLR_W'(lse_zero_second);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg.llr_first_bit  <= sat16(llr_first);
            out_reg.llr_second_bit <= sat16(llr_second);
        end
    end

    assign llr_valid = valid_reg[PIPE_DEPTH-1];
    assign llr_data  = out_reg;

endmodule

// File: verif/tb_qpsk_logmap_soft_demapper.sv
// ----------------------------------------------------------------------------
// tb_qpsk_logmap_soft_demapper
// Self-checking bench for the QPSK log-MAP soft demapper. A short table of
// directed samples is followed by random samples under several noise
// register settings. Each result word is checked against a typed-in word or
// a fixed-point predictor of the LLR datapath. Both streams idle at random.
// ----------------------------------------------------------------------------
module tb_qpsk_logmap_soft_demapper
    import qlm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CORR_DEPTH   = 16;
    localparam int LATENCY      = 7;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_ITEMS  = 250;
    localparam int PHASES       = 8;

    // Directed table columns
    localparam int COL_INV   = 0;
    localparam int COL_RE    = 1;
    localparam int COL_IM    = 2;
    localparam int COL_KNOWN = 3;
    localparam int COL_LLR0  = 4;
    localparam int COL_LLR1  = 5;
    localparam int N_PROBES  = 22;

    // noise register, I, Q, typed-in flag, LLR of first bit, LLR of second bit
    localparam int PROBES [N_PROBES][6] = '{
        '{256,        0,      0, 1,      0,      0},
        '{256,     1448,   1448, 0,      0,      0},
        '{256,    -1448,  -1448, 0,      0,      0},
        '{256,     1448,  -1448, 0,      0,      0},
        '{256,    -1448,   1448, 0,      0,      0},
        '{256,    32767, -32768, 0,      0,      0},
        '{256,   -32768,  32767, 0,      0,      0},
        '{256,       16,    -16, 0,      0,      0},
        '{256,      200,   -700, 0,      0,      0},
        '{256,     3000,  -5000, 0,      0,      0},
        '{0,      32767,  32767, 1,      0,      0},
        '{0,     -32768,  12345, 1,      0,      0},
        '{0,          0,      0, 1,      0,      0},
        '{65535, -32768, -32768, 1,  32767,  32767},
        '{65535,  32767,  32767, 1, -32768, -32768},
        '{65535, -32768,  32767, 1,  32767, -32768},
        '{65535,      0,      0, 0,      0,      0},
        '{65535,      1,     -1, 0,      0,      0},
        '{1,          0,      0, 1,      0,      0},
        '{1,      32767, -32768, 0,      0,      0},
        '{32768,   5000,  -5000, 0,      0,      0},
        '{32768,     -1,      0, 0,      0,      0}
    };

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        rx_valid    = 1'b0;
    logic        rx_ready;
    rx_word_t    rx_data     = '0;
    logic        llr_valid;
    logic        llr_ready   = 1'b0;
    llr_word_t   llr_data;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;

    llr_word_t   pending_llr [$];
    logic [15:0] noise_reg_model = INV_NOISE_RESET;
    int          mismatch_count  = 0;
    int          cycle_count     = 0;

    // receiver stall state
    int          stall_left = 0;
    int          mode_left  = 0;
    bit          rx_calm    = 1'b0;

    qpsk_logmap_soft_demapper #(
        .CORR_TABLE_DEPTH (CORR_DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_valid    (rx_valid),
        .rx_ready    (rx_ready),
        .rx_data     (rx_data),
        .llr_valid   (llr_valid),
        .llr_ready   (llr_ready),
        .llr_data    (llr_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Rounded per-axis penalty in Q.7: squared error scaled by the register
    function automatic longint axis_penalty(longint y, longint coord, logic [15:0] inv);
        longint          e;
        longint unsigned d;
        longint unsigned p;
        e = y - coord;
        d = e * e;
        p = d * inv;
        return longint'((p + (64'd1 << (RND_SHIFT - 1))) >> RND_SHIFT);
    endfunction

    // Max plus the stepped log(1+exp(-x)) correction
    function automatic longint lse_pair(longint a, longint b);
        longint top;
        longint gap;
        longint bin;
        top = (a > b) ? a : b;
        gap = (a > b) ? a - b : b - a;
        if (gap >= CORR_RANGE_Q7)
            return top;
        bin = (gap * CORR_DEPTH) / CORR_RANGE_Q7;
        return top + longint'(CORR_MASTER[(bin * MASTER_LEN) / CORR_DEPTH]);
    endfunction

    function automatic logic signed [15:0] clip16(longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    // Predict both LLRs of one sample
    function automatic llr_word_t demap_llr(rx_word_t w, logic [15:0] inv);
        longint    yr;
        longint    yi;
        longint    r0, r1, i0, i1;
        longint    m0, m1, m2, m3;
        llr_word_t res;
        yr = longint'(w.rx_real);
        yi = longint'(w.rx_imag);
        r0 = axis_penalty(yr, COORD_Q11, inv);
        r1 = axis_penalty(yr, -COORD_Q11, inv);
        i0 = axis_penalty(yi, COORD_Q11, inv);
        i1 = axis_penalty(yi, -COORD_Q11, inv);
        m0 = -(r0 + i0);
        m1 = -(r0 + i1);
        m2 = -(r1 + i0);
        m3 = -(r1 + i1);
        res.llr_first_bit  = clip16(lse_pair(m2, m3) - lse_pair(m0, m1));
        res.llr_second_bit = clip16(lse_pair(m1, m3) - lse_pair(m0, m2));
        return res;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // One axis: full range, near a constellation coordinate, or near zero
    function automatic logic signed [15:0] pick_axis();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 16'($urandom);
        if (r < 8)
            return 16'(($urandom_range(0, 1) ? COORD_Q11 : -COORD_Q11)
                       + $urandom_range(0, 4095) - 2048);
        return 16'($urandom_range(0, 127) - 64);
    endfunction

    // Present one sample, hold it until taken, then queue its expected LLRs
    task automatic push_sample(input rx_word_t w, input bit known, input llr_word_t typed);
        rx_valid <= 1'b1;
        rx_data  <= w;
        do
            @(posedge clk);
        while (!rx_ready);
        pending_llr.insert(pending_llr.size(),
                           known ? typed : demap_llr(w, noise_reg_model));
    endtask

    task automatic idle_tx(input bit calm);
        int g;
        g = calm ? 0 : pick_gap();
        if (g > 0)
        begin
            rx_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Drain the pipeline, then write the noise register
    task automatic write_noise_reg(input logic [15:0] v);
        rx_valid <= 1'b0;
        while (pending_llr.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en       <= 1'b0;
        noise_reg_model  = v;
    endtask

    // Receiver: alternate calm stretches with random stalls
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            rx_calm   = ($urandom_range(0, 3) == 0);
            mode_left = $urandom_range(50, 300);
        end
        else
            mode_left--;
        if (stall_left > 0)
        begin
            stall_left--;
            llr_ready <= 1'b0;
        end
        else if (!rx_calm && $urandom_range(0, 2) == 0)
        begin
            stall_left = pick_gap();
            llr_ready <= 1'b0;
        end
        else
            llr_ready <= 1'b1;
    end

    // Check each taken word against the oldest expectation
    always @(posedge clk)
    begin
        llr_word_t want;
        if (rst_n && llr_valid && llr_ready)
        begin
            if (pending_llr.size() == 0)
            begin
                $error("unexpected word: llr_first_bit %0d, llr_second_bit %0d",
                       llr_data.llr_first_bit, llr_data.llr_second_bit);
                mismatch_count++;
            end
            else
            begin
                want = pending_llr.pop_front();
                if (llr_data.llr_first_bit !== want.llr_first_bit)
                begin
                    $error("llr_first_bit: expected %0d, actual %0d",
                           want.llr_first_bit, llr_data.llr_first_bit);
                    mismatch_count++;
                end
                if (llr_data.llr_second_bit !== want.llr_second_bit)
                begin
                    $error("llr_second_bit: expected %0d, actual %0d",
                           want.llr_second_bit, llr_data.llr_second_bit);
                    mismatch_count++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int          n;
        int          phase;
        int          k;
        logic [15:0] reg_val;
        rx_word_t    w;
        llr_word_t   typed;

        // Hold reset, then release it
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: the first rows run on the reset value of the register
        for (n = 0; n < N_PROBES; n++)
        begin
            if (16'(PROBES[n][COL_INV]) != noise_reg_model)
                write_noise_reg(16'(PROBES[n][COL_INV]));
            w.rx_real            = 16'(PROBES[n][COL_RE]);
            w.rx_imag            = 16'(PROBES[n][COL_IM]);
            typed.llr_first_bit  = 16'(PROBES[n][COL_LLR0]);
            typed.llr_second_bit = 16'(PROBES[n][COL_LLR1]);
            push_sample(w, PROBES[n][COL_KNOWN] != 0, typed);
            idle_tx(1'b0);
        end

        // Random samples, one register setting per phase
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       reg_val = INV_NOISE_RESET;
                1:       reg_val = 16'($urandom_range(0, 1023));
                2:       reg_val = 16'hffff;
                3:       reg_val = 16'h0000;
                5:       reg_val = 16'($urandom_range(1, 8));
                6:       reg_val = 16'($urandom_range(128, 4096));
                default: reg_val = 16'($urandom);
            endcase
            write_noise_reg(reg_val);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                w.rx_real = pick_axis();
                w.rx_imag = pick_axis();
                push_sample(w, 1'b0, '0);
                idle_tx(phase % 3 == 1);
            end
        end

        // Drain and let the pipeline settle
        rx_valid <= 1'b0;
        while (pending_llr.size() != 0)
            @(posedge clk);
        repeat (4 * LATENCY) @(posedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
